FILE: rtl/ctq_pkg.sv
// Shared codes, widths and defaults for the cost-sorted tour queue.
`default_nettype none
package ctq_pkg;
    localparam int QUEUE_CAPACITY_DEF = 64;
    localparam int MAX_TOUR_DEF       = 16;
    localparam int QUEUE_DEPTH        = 2;

    localparam int COST_W   = 31;
    localparam int LEN_W    = 5;
    localparam int CITY_W   = 8;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 7;

    localparam logic OP_ENQ = 1'b0;
    localparam logic OP_DEQ = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;
endpackage
`default_nettype wire

FILE: rtl/cost_sorted_tour_queue_unit.sv
// Cost-sorted tour queue: top level joining front, request queue and back.
// An enqueue city request with last_city low is only staged and gives no result.
// With the back idle, a final-city enqueue takes a freed slot from the free list
// or else a fresh slot, writes the city row one city per cycle, walks the sorted
// list past held entries of equal or lower cost, reading one linked entry per
// cycle from the slot memories, stops at a costlier entry or the list end, links
// the entry in (with a second link write when it lands behind another) and gives
// its status. A dequeue streams its cities one per cycle, the last with o_last; a
// zero-length entry gives a single result and an empty queue an ST_EMPTY status.
// Two commands can wait between front and back; busy rises when both wait.
// Results appear for one cycle with o_strobe and cannot be held off.
`default_nettype none
module cost_sorted_tour_queue_unit import ctq_pkg::*; #(
    parameter int QUEUE_CAPACITY = QUEUE_CAPACITY_DEF,
    parameter int MAX_TOUR       = MAX_TOUR_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire logic                i_operation,
    input  wire logic [COST_W-1:0]   i_cost,
    input  wire logic [LEN_W-1:0]    i_tour_length,
    input  wire logic [CITY_W-1:0]   i_city,
    input  wire logic                i_last_city,
    output logic                     o_strobe,
    output logic [STATUS_W-1:0]      o_status,
    output logic [COST_W-1:0]        o_out_cost,
    output logic [LEN_W-1:0]         o_out_length,
    output logic [CITY_W-1:0]        o_out_city,
    output logic                     o_last,
    output logic [COUNT_W-1:0]       o_entry_count
);
    localparam int FW    = $clog2(MAX_TOUR + 1);
    localparam int CMD_W = 1 + COST_W + LEN_W + FW + MAX_TOUR * CITY_W;

    logic             accept, push, pop, q_empty, q_full;
    logic [CMD_W-1:0] cmd_in, cmd_out;

    assign busy   = q_full;
    assign accept = start && !q_full;

    ctq_front #(.MAX_TOUR(MAX_TOUR), .CMD_W(CMD_W)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_accept(accept),
        .i_operation(i_operation), .i_cost(i_cost), .i_tour_length(i_tour_length),
        .i_city(i_city), .i_last_city(i_last_city),
        .o_push(push), .o_cmd(cmd_in)
    );

    ctq_queue #(.W(CMD_W)) u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .i_data(cmd_in),
        .i_pop(pop), .o_data(cmd_out), .o_empty(q_empty), .o_full(q_full)
    );

    ctq_back #(.QUEUE_CAPACITY(QUEUE_CAPACITY), .MAX_TOUR(MAX_TOUR), .CMD_W(CMD_W)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd_empty(q_empty), .i_cmd(cmd_out),
        .o_pop(pop), .o_strobe(o_strobe), .o_status(o_status),
        .o_out_cost(o_out_cost), .o_out_length(o_out_length), .o_out_city(o_out_city),
        .o_last(o_last), .o_entry_count(o_entry_count)
    );
endmodule
`default_nettype wire

FILE: rtl/ctq_queue.sv
// Short request queue between the front and the back.
`default_nettype none
module ctq_queue import ctq_pkg::*; #(
    parameter int W = 8
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_push,
    input  wire logic [W-1:0] i_data,
    input  wire logic         i_pop,
    output logic [W-1:0]      o_data,
    output logic              o_empty,
    output logic              o_full
);
    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [W-1:0]  r_mem [QUEUE_DEPTH];
    logic [PW-1:0] r_wp, r_rp;
    logic [CW-1:0] r_cnt;

    assign o_data  = r_mem[r_rp];
    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == CW'(QUEUE_DEPTH));

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == PW'(QUEUE_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == PW'(QUEUE_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + CW'(i_push) - CW'(i_pop);
        end
    end
endmodule
`default_nettype wire

FILE: rtl/ctq_front.sv
// Front: takes requests, stages tour cities and queues whole commands.
`default_nettype none
module ctq_front import ctq_pkg::*; #(
    parameter int MAX_TOUR = MAX_TOUR_DEF,
    parameter int CMD_W    = 8
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_accept,
    input  wire logic              i_operation,
    input  wire logic [COST_W-1:0] i_cost,
    input  wire logic [LEN_W-1:0]  i_tour_length,
    input  wire logic [CITY_W-1:0] i_city,
    input  wire logic              i_last_city,
    output logic                   o_push,
    output logic [CMD_W-1:0]       o_cmd
);
    localparam int FW = $clog2(MAX_TOUR + 1);

    logic [MAX_TOUR*CITY_W-1:0] r_stage, n_stage;
    logic [FW-1:0]              r_fill, n_fill;

    always_comb begin
        n_stage = r_stage;
        n_fill  = r_fill;
        if (i_accept && i_operation == OP_ENQ && r_fill < FW'(MAX_TOUR)) begin
            for (int i = 0; i < MAX_TOUR; i++) begin
                if (r_fill == FW'(i)) begin
                    n_stage[i*CITY_W +: CITY_W] = i_city;
                end
            end
            n_fill = r_fill + 1'b1;
        end
    end

    assign o_push = i_accept && (i_operation == OP_DEQ || i_last_city);
    assign o_cmd  = {i_operation, i_cost, i_tour_length, n_fill, n_stage};

    always_ff @(posedge i_clk) begin
        r_stage <= n_stage;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (i_accept && i_operation == OP_ENQ && i_last_city) begin
            r_fill <= '0;
        end else begin
            r_fill <= n_fill;
        end
    end
endmodule
`default_nettype wire

FILE: rtl/ctq_back.sv
// Back: linked slot pool, sorted insertion walk and dequeue streaming.
`default_nettype none
module ctq_back import ctq_pkg::*; #(
    parameter int QUEUE_CAPACITY = QUEUE_CAPACITY_DEF,
    parameter int MAX_TOUR       = MAX_TOUR_DEF,
    parameter int CMD_W          = 8
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cmd_empty,
    input  wire logic [CMD_W-1:0]    i_cmd,
    output logic                     o_pop,
    output logic                     o_strobe,
    output logic [STATUS_W-1:0]      o_status,
    output logic [COST_W-1:0]        o_out_cost,
    output logic [LEN_W-1:0]         o_out_length,
    output logic [CITY_W-1:0]        o_out_city,
    output logic                     o_last,
    output logic [COUNT_W-1:0]       o_entry_count
);
    localparam int FW = $clog2(MAX_TOUR + 1);
    localparam int IW = $clog2(MAX_TOUR);
    localparam int AW = $clog2(QUEUE_CAPACITY);
    localparam int SW = $clog2(QUEUE_CAPACITY + 1);
    localparam int CAW = AW + IW;
    localparam int VW = MAX_TOUR * CITY_W;
    localparam logic [SW-1:0] NULL_SLOT = SW'(QUEUE_CAPACITY);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_POP   = 4'd1;
    localparam logic [3:0] S_FILL  = 4'd2;
    localparam logic [3:0] S_WSTRT = 4'd3;
    localparam logic [3:0] S_WALK  = 4'd4;
    localparam logic [3:0] S_LINK  = 4'd5;
    localparam logic [3:0] S_LINK2 = 4'd6;
    localparam logic [3:0] S_DQ1   = 4'd7;
    localparam logic [3:0] S_EMIT  = 4'd8;

    // command fields
    logic              c_op;
    logic [COST_W-1:0] c_cost;
    logic [LEN_W-1:0]  c_len;
    logic [FW-1:0]     c_fill;
    logic [VW-1:0]     c_cities;
    assign {c_op, c_cost, c_len, c_fill, c_cities} = i_cmd;

    // memories
    logic [COST_W-1:0] m_cost [QUEUE_CAPACITY];
    logic [LEN_W-1:0]  m_len  [QUEUE_CAPACITY];
    logic [SW-1:0]     m_link [QUEUE_CAPACITY];
    logic [CITY_W-1:0] m_city [2**CAW];

    logic [COST_W-1:0] cost_rd;
    logic [LEN_W-1:0]  len_rd;
    logic [SW-1:0]     link_rd;
    logic [CITY_W-1:0] city_rd;

    logic              slot_we, link_we, city_we;
    logic [AW-1:0]     rd_addr, link_waddr;
    logic [SW-1:0]     link_wdata;
    logic [CAW-1:0]    city_waddr, city_raddr;
    logic [CITY_W-1:0] city_wdata;

    logic [3:0]        r_state, n_state;
    logic [COST_W-1:0] r_cost, n_cost;
    logic [LEN_W-1:0]  r_len, n_len;
    logic [FW-1:0]     r_fill, n_fill;
    logic [VW-1:0]     r_cities, n_cities;
    logic [SW-1:0]     r_slot, n_slot;
    logic [SW-1:0]     r_cur, n_cur;
    logic [SW-1:0]     r_prev, n_prev;
    logic              r_prev_null, n_prev_null;
    logic [SW-1:0]     r_head, n_head;
    logic [SW-1:0]     r_free_head, n_free_head;
    logic [SW-1:0]     r_fresh, n_fresh;
    logic [SW-1:0]     r_count, n_count;
    logic [IW-1:0]     r_idx, n_idx;

    logic                r_strobe, n_strobe;
    logic [STATUS_W-1:0] r_status, n_status;
    logic [COST_W-1:0]   r_ocost, n_ocost;
    logic [LEN_W-1:0]    r_olen, n_olen;
    logic [CITY_W-1:0]   r_ocity, n_ocity;
    logic                r_olast, n_olast;
    logic [SW-1:0]       r_ocount, n_ocount;

    logic              emit_last;
    logic [CITY_W-1:0] fill_city;

    assign emit_last = ((7'(r_idx) + 7'd1) == 7'(r_len));
    assign fill_city = (FW'(r_idx) < r_fill) ? r_cities[r_idx*CITY_W +: CITY_W] : '0;

    always_comb begin
        n_state     = r_state;
        n_cost      = r_cost;
        n_len       = r_len;
        n_fill      = r_fill;
        n_cities    = r_cities;
        n_slot      = r_slot;
        n_cur       = r_cur;
        n_prev      = r_prev;
        n_prev_null = r_prev_null;
        n_head      = r_head;
        n_free_head = r_free_head;
        n_fresh     = r_fresh;
        n_count     = r_count;
        n_idx       = r_idx;
        n_strobe    = 1'b0;
        n_status    = ST_OK;
        n_ocost     = '0;
        n_olen      = '0;
        n_ocity     = '0;
        n_olast     = 1'b1;
        n_ocount    = r_count;
        o_pop       = 1'b0;
        slot_we     = 1'b0;
        link_we     = 1'b0;
        city_we     = 1'b0;
        rd_addr     = r_slot[AW-1:0];
        link_waddr  = r_slot[AW-1:0];
        link_wdata  = r_cur;
        city_waddr  = {r_slot[AW-1:0], r_idx};
        city_wdata  = fill_city;
        city_raddr  = {r_slot[AW-1:0], r_idx};

        case (r_state)
            S_IDLE: begin
                if (!i_cmd_empty) begin
                    o_pop    = 1'b1;
                    n_cost   = c_cost;
                    n_len    = (32'(c_len) > MAX_TOUR) ? LEN_W'(MAX_TOUR) : c_len;
                    n_fill   = c_fill;
                    n_cities = c_cities;
                    n_idx    = '0;
                    if (c_op == OP_DEQ) begin
                        if (r_head == NULL_SLOT) begin
                            n_strobe = 1'b1;
                            n_status = ST_EMPTY;
                        end else begin
                            n_slot  = r_head;
                            rd_addr = r_head[AW-1:0];
                            n_state = S_DQ1;
                        end
                    end else if (r_count >= SW'(QUEUE_CAPACITY)) begin
                        n_strobe = 1'b1;
                        n_status = ST_FULL;
                    end else if (r_free_head != NULL_SLOT) begin
                        n_slot  = r_free_head;
                        rd_addr = r_free_head[AW-1:0];
                        n_state = S_POP;
                    end else begin
                        n_slot  = r_fresh;
                        n_fresh = r_fresh + 1'b1;
                        n_state = S_FILL;
                    end
                end
            end
            S_POP: begin
                n_free_head = link_rd;
                n_state     = S_FILL;
            end
            S_FILL: begin
                city_we = 1'b1;
                slot_we = (r_idx == '0);
                if (r_idx == IW'(MAX_TOUR - 1)) begin
                    n_state = S_WSTRT;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_WSTRT: begin
                n_prev_null = 1'b1;
                n_cur       = r_head;
                rd_addr     = r_head[AW-1:0];
                n_state     = (r_head == NULL_SLOT) ? S_LINK : S_WALK;
            end
            S_WALK: begin
                // step past entries of equal or lower cost
                if (cost_rd <= r_cost) begin
                    n_prev      = r_cur;
                    n_prev_null = 1'b0;
                    n_cur       = link_rd;
                    rd_addr     = link_rd[AW-1:0];
                    if (link_rd == NULL_SLOT) begin
                        n_state = S_LINK;
                    end
                end else begin
                    n_state = S_LINK;
                end
            end
            S_LINK: begin
                link_we = 1'b1;
                if (r_prev_null) begin
                    n_head   = r_slot;
                    n_count  = r_count + 1'b1;
                    n_strobe = 1'b1;
                    n_ocount = r_count + 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    n_state = S_LINK2;
                end
            end
            S_LINK2: begin
                link_we    = 1'b1;
                link_waddr = r_prev[AW-1:0];
                link_wdata = r_slot;
                n_count    = r_count + 1'b1;
                n_strobe   = 1'b1;
                n_ocount   = r_count + 1'b1;
                n_state    = S_IDLE;
            end
            S_DQ1: begin
                n_head      = link_rd;
                link_we     = 1'b1;
                link_wdata  = r_free_head;
                n_free_head = r_slot;
                n_count     = r_count - 1'b1;
                n_cost      = cost_rd;
                n_len       = len_rd;
                city_raddr  = {r_slot[AW-1:0], IW'(0)};
                if (len_rd == '0) begin
                    n_strobe = 1'b1;
                    n_ocost  = cost_rd;
                    n_ocount = r_count - 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                n_strobe   = 1'b1;
                n_ocost    = r_cost;
                n_olen     = r_len;
                n_ocity    = city_rd;
                n_olast    = emit_last;
                n_idx      = r_idx + 1'b1;
                city_raddr = {r_slot[AW-1:0], r_idx + 1'b1};
                if (emit_last) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (slot_we) begin
            m_cost[r_slot[AW-1:0]] <= r_cost;
            m_len[r_slot[AW-1:0]]  <= r_len;
        end
        if (link_we) begin
            m_link[link_waddr] <= link_wdata;
        end
        if (city_we) begin
            m_city[city_waddr] <= city_wdata;
        end
        cost_rd <= m_cost[rd_addr];
        len_rd  <= m_len[rd_addr];
        link_rd <= m_link[rd_addr];
        city_rd <= m_city[city_raddr];
    end

    always_ff @(posedge i_clk) begin
        r_cost   <= n_cost;
        r_len    <= n_len;
        r_fill   <= n_fill;
        r_cities <= n_cities;
        r_slot   <= n_slot;
        r_cur    <= n_cur;
        r_prev   <= n_prev;
        r_idx    <= n_idx;
        r_status <= n_status;
        r_ocost  <= n_ocost;
        r_olen   <= n_olen;
        r_ocity  <= n_ocity;
        r_olast  <= n_olast;
        r_ocount <= n_ocount;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_prev_null <= 1'b1;
            r_head      <= NULL_SLOT;
            r_free_head <= NULL_SLOT;
            r_fresh     <= '0;
            r_count     <= '0;
            r_strobe    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_prev_null <= n_prev_null;
            r_head      <= n_head;
            r_free_head <= n_free_head;
            r_fresh     <= n_fresh;
            r_count     <= n_count;
            r_strobe    <= n_strobe;
        end
    end

    assign o_strobe      = r_strobe;
    assign o_status      = r_status;
    assign o_out_cost    = r_ocost;
    assign o_out_length  = r_olen;
    assign o_out_city    = r_ocity;
    assign o_last        = r_olast;
    assign o_entry_count = COUNT_W'(r_ocount);
endmodule
`default_nettype wire

FILE: tb/sv/cost_sorted_tour_queue_unit_tb.sv
// Self-checking testbench for the cost-sorted tour queue unit.
module cost_sorted_tour_queue_unit_tb;
    import ctq_pkg::*;

    localparam int CAP       = QUEUE_CAPACITY_DEF;
    localparam int TOUR_MAX  = MAX_TOUR_DEF;
    localparam int NIL       = CAP;
    localparam int N_ITEMS   = 450;
    localparam int STALL_MAX = 3000;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [COST_W-1:0]   cost;
        logic [LEN_W-1:0]    length;
        logic [CITY_W-1:0]   city;
        logic                last;
        logic [COUNT_W-1:0]  count;
    } tour_result_t;

    class tour_queue_board;
        logic [COST_W-1:0] slot_cost [CAP];
        logic [LEN_W-1:0]  slot_len  [CAP];
        logic [CITY_W-1:0] slot_city [CAP][TOUR_MAX];
        int                link      [CAP];
        int                head, free_slot, held, fill;
        logic [CITY_W-1:0] stage     [TOUR_MAX];
        tour_result_t      awaited   [$];
        int                errors;

        function new();
            for (int i = 0; i < CAP; i++) link[i] = i + 1;
            head = NIL;
            free_slot = 0;
            held = 0;
            fill = 0;
            errors = 0;
        endfunction

        function void push(logic [STATUS_W-1:0] st, logic [COST_W-1:0] c,
                           logic [LEN_W-1:0] len, logic [CITY_W-1:0] cy, logic lst);
            tour_result_t r;
            r.status = st;
            r.cost = c;
            r.length = len;
            r.city = cy;
            r.last = lst;
            r.count = held[COUNT_W-1:0];
            awaited.push_back(r);
        endfunction

        // Note an accepted request and queue the results it causes.
        function void note_request(logic op, logic [COST_W-1:0] c, logic [LEN_W-1:0] len_in,
                                   logic [CITY_W-1:0] cy, logic lastc);
            int slot, prev, cur, steps, len;
            if (op == OP_DEQ) begin
                if (head >= CAP || held == 0) begin
                    push(ST_EMPTY, '0, '0, '0, 1'b1);
                    return;
                end
                slot = head;
                len = slot_len[slot];
                if (len > TOUR_MAX) len = TOUR_MAX;
                head = link[slot];
                link[slot] = free_slot;
                free_slot = slot;
                held--;
                if (len == 0) push(ST_OK, slot_cost[slot], '0, '0, 1'b1);
                for (int i = 0; i < len; i++)
                    push(ST_OK, slot_cost[slot], len[LEN_W-1:0], slot_city[slot][i],
                         i + 1 == len);
                return;
            end
            if (fill < TOUR_MAX) begin
                stage[fill] = cy;
                fill++;
            end
            if (!lastc) return;
            if (held >= CAP || free_slot >= CAP) begin
                fill = 0;
                push(ST_FULL, '0, '0, '0, 1'b1);
                return;
            end
            len = len_in;
            if (len > TOUR_MAX) len = TOUR_MAX;
            slot = free_slot;
            free_slot = link[slot];
            slot_cost[slot] = c;
            slot_len[slot] = len[LEN_W-1:0];
            for (int i = 0; i < TOUR_MAX; i++) slot_city[slot][i] = (i < fill) ? stage[i] : '0;
            fill = 0;
            prev = NIL;
            cur = head;
            steps = 0;
            while (cur < CAP && steps < CAP && slot_cost[cur] <= c) begin
                prev = cur;
                cur = link[cur];
                steps++;
            end
            link[slot] = cur;
            if (prev == NIL) head = slot;
            else link[prev] = slot;
            held++;
            push(ST_OK, '0, '0, '0, 1'b1);
        endfunction

        function void check_result(tour_result_t got);
            tour_result_t want;
            if (awaited.size() == 0) begin
                $display("%0t: unexpected result %p", $time, got);
                errors++;
                return;
            end
            want = awaited.pop_front();
            if (got.status !== want.status) begin
                $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
                errors++;
            end
            if (got.cost !== want.cost) begin
                $display("%0t: out_cost expected %0d actual %0d", $time, want.cost, got.cost);
                errors++;
            end
            if (got.length !== want.length) begin
                $display("%0t: out_length expected %0d actual %0d", $time, want.length,
                         got.length);
                errors++;
            end
            if (got.city !== want.city) begin
                $display("%0t: out_city expected %0d actual %0d", $time, want.city, got.city);
                errors++;
            end
            if (got.last !== want.last) begin
                $display("%0t: last expected %0d actual %0d", $time, want.last, got.last);
                errors++;
            end
            if (got.count !== want.count) begin
                $display("%0t: entry_count expected %0d actual %0d", $time, want.count,
                         got.count);
                errors++;
            end
        endfunction
    endclass

    logic                i_clk;
    logic                i_rst_n;
    logic                start;
    logic                busy;
    logic                i_operation;
    logic [COST_W-1:0]   i_cost;
    logic [LEN_W-1:0]    i_tour_length;
    logic [CITY_W-1:0]   i_city;
    logic                i_last_city;
    logic                o_strobe;
    logic [STATUS_W-1:0] o_status;
    logic [COST_W-1:0]   o_out_cost;
    logic [LEN_W-1:0]    o_out_length;
    logic [CITY_W-1:0]   o_out_city;
    logic                o_last;
    logic [COUNT_W-1:0]  o_entry_count;

    tour_queue_board board = new();
    int  sent = 0;
    int  quiet = 0;
    bit  no_gaps = 0;

    cost_sorted_tour_queue_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_operation(i_operation), .i_cost(i_cost), .i_tour_length(i_tour_length),
        .i_city(i_city), .i_last_city(i_last_city), .o_strobe(o_strobe),
        .o_status(o_status), .o_out_cost(o_out_cost), .o_out_length(o_out_length),
        .o_out_city(o_out_city), .o_last(o_last), .o_entry_count(o_entry_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe)
            board.check_result('{o_status, o_out_cost, o_out_length, o_out_city, o_last,
                                 o_entry_count});
    end

    // Count cycles without progress on either side.
    always @(posedge i_clk) begin
        if (!i_rst_n || o_strobe || (start && !busy)) quiet <= 0;
        else quiet <= quiet + 1;
        if (quiet >= STALL_MAX) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Drive one request and hold it until accepted.
    task automatic send(logic op, logic [COST_W-1:0] c, logic [LEN_W-1:0] len,
                        logic [CITY_W-1:0] cy, logic lastc);
        @(negedge i_clk);
        start <= 1'b1;
        i_operation <= op;
        i_cost <= c;
        i_tour_length <= len;
        i_city <= cy;
        i_last_city <= lastc;
        do @(posedge i_clk); while (busy);
        board.note_request(op, c, len, cy, lastc);
        sent++;
        if (!no_gaps && $urandom_range(99) < 8) begin
            @(negedge i_clk);
            start <= 1'b0;
            repeat ($urandom_range(4)) @(negedge i_clk);
        end
    endtask

    function automatic logic [COST_W-1:0] pick_cost();
        int k;
        k = $urandom_range(9);
        if (k < 5) return COST_W'($urandom_range(7));
        if (k == 5) return '0;
        if (k == 6) return '1;
        return COST_W'($urandom);
    endfunction

    // Send a whole tour of n cities; the final item carries cost and length.
    task automatic send_tour(int n, logic [COST_W-1:0] c, logic [LEN_W-1:0] len);
        for (int i = 0; i < n; i++) begin
            if (i + 1 < n && $urandom_range(19) == 0)
                send(OP_DEQ, COST_W'($urandom), LEN_W'($urandom), CITY_W'($urandom),
                     1'($urandom));
            send(OP_ENQ, (i + 1 == n) ? c : COST_W'($urandom),
                 (i + 1 == n) ? len : LEN_W'($urandom), CITY_W'($urandom), i + 1 == n);
        end
    endtask

    initial begin
        int n, mode, deq_pct;
        logic [LEN_W-1:0] len;
        start = 1'b0;
        i_operation = OP_ENQ;
        i_cost = '0;
        i_tour_length = '0;
        i_city = '0;
        i_last_city = 1'b0;
        i_rst_n = 1'b0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: empty dequeue, extremes, zero length, ties, saturation
        send(OP_DEQ, '0, '0, '0, 1'b0);
        send(OP_ENQ, '0, 5'd1, 8'd0, 1'b1);
        send(OP_ENQ, '1, '1, 8'hFF, 1'b0);
        send(OP_ENQ, '1, '1, 8'hAA, 1'b0);
        send(OP_ENQ, '1, 5'd3, 8'h55, 1'b1);
        send(OP_ENQ, 31'd5, 5'd0, 8'd7, 1'b1);
        send(OP_ENQ, 31'd5, 5'd2, 8'd9, 1'b0);
        send(OP_DEQ, '1, '1, '1, 1'b1);
        send(OP_ENQ, 31'd5, 5'd2, 8'd10, 1'b1);
        send(OP_ENQ, 31'd2, 5'd31, 8'd33, 1'b0);
        send(OP_ENQ, 31'd2, 5'd31, 8'd44, 1'b1);
        send(OP_ENQ, 31'h40000000, 5'd16, 8'h80, 1'b1);
        repeat (7) send(OP_DEQ, '0, '0, '0, 1'b0);

        while (sent < N_ITEMS) begin
            mode = $urandom_range(3);
            no_gaps = ($urandom_range(5) == 0);
            deq_pct = (mode == 0) ? 5 : (mode == 1) ? 70 : 35;
            for (int t = 0; t < 12 && sent < N_ITEMS; t++) begin
                if ($urandom_range(99) < deq_pct) begin
                    send(OP_DEQ, COST_W'($urandom), LEN_W'($urandom), CITY_W'($urandom),
                         1'($urandom));
                    continue;
                end
                if (mode == 0) n = $urandom_range(1, 2);
                else if ($urandom_range(19) == 0) n = $urandom_range(17, 20);
                else n = $urandom_range(1, 6);
                len = ($urandom_range(3) == 0) ? LEN_W'($urandom) : LEN_W'(n);
                send_tour(n, pick_cost(), len);
            end
            // fill phases keep going until the pool overflows
            if (mode == 0)
                while (board.held < CAP) send_tour(1, pick_cost(), 5'd1);
            if (mode == 0) send_tour(2, pick_cost(), 5'd2);
        end
        no_gaps = 1'b0;
        @(negedge i_clk);
        start <= 1'b0;

        while (board.awaited.size() != 0) @(posedge i_clk);
        repeat (120) @(posedge i_clk);
        if (board.errors == 0 && board.awaited.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule
